/* rtl/gzsp_pkg.sv */
package gzsp_pkg;

  // Size registers are 11 bits wide
  localparam int CFG_W = 11;
  // Path sums reach +/-(2*2047-1), so one bit beyond the size width plus sign
  localparam int SUM_W = CFG_W + 2;
  localparam int OUT_W = 12;
  // Cell counts reach 2047*2047
  localparam int CNT_W = 2 * CFG_W;

  localparam int DEFAULT_MAX_ROWS    = 1024;
  localparam int DEFAULT_MAX_COLUMNS = 1024;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic plus;
  } step_ctl_t;

  function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > hi) begin
      r = CFG_W'(hi);
    end
    return r;
  endfunction

endpackage

/* rtl/gzsp_step.sv */
module gzsp_step (
  input  gzsp_pkg::step_ctl_t ctl,
  input  gzsp_pkg::sum_t      up_min,
  input  gzsp_pkg::sum_t      up_max,
  input  gzsp_pkg::sum_t      left_min,
  input  gzsp_pkg::sum_t      left_max,
  output gzsp_pkg::sum_t      lo,
  output gzsp_pkg::sum_t      hi
);

  gzsp_pkg::sum_t v;
  gzsp_pkg::sum_t base_min;
  gzsp_pkg::sum_t base_max;

  assign v = ctl.plus ? gzsp_pkg::sum_t'(1) : gzsp_pkg::sum_t'(-1);

  always_comb begin
    if (ctl.first_row && ctl.first_col) begin
      base_min = '0;
      base_max = '0;
    end else if (ctl.first_row) begin
      base_min = left_min;
      base_max = left_max;
    end else if (ctl.first_col) begin
      base_min = up_min;
      base_max = up_max;
    end else begin
      base_min = (up_min < left_min) ? up_min : left_min;
      base_max = (up_max > left_max) ? up_max : left_max;
    end
  end

  assign lo = base_min + v;
  assign hi = base_max + v;

endmodule

/* rtl/grid_zero_sum_path_check_core.sv */
// Zero-sum path check over a grid of +1/-1 cells.
// Configure row_count (index 0) and column_count (index 1) through cfg_we,
// cfg_index and cfg_data while the block is idle; any write restarts the grid.
// A size of 0 acts as 1, a size above MAX_ROWS/MAX_COLUMNS acts as the maximum.
// Cells enter on in_valid/in_ready in row-major order, one per cycle while ready.
// Each cell reads the row buffer entry of its column on entry and writes it back
// in the next cycle; a same-column collision (single-column grids) is forwarded.
// After the last cell of a grid, one result (zero_path_exists, least_path_sum,
// greatest_path_sum) passes through the update stage and the output buffer to
// out_valid/out_ready, and the next grid can start right behind it.
// Throughput is one cell per cycle while the buffer has room, also for grids of a
// single cell. Results wait in a two-entry output buffer. A final cell waits at
// the input only while that buffer, counting a result still in the update stage
// and less a result taken this cycle, holds two results; a stalled receiver thus
// holds the block at the final cell of the third grid that it has not taken.
// Reset (rst, synchronous) sets both sizes to 1, empties the pipeline and the
// output buffer, and starts a new grid. Row buffer contents are not cleared;
// the top row of each grid writes every entry before it is read.
module grid_zero_sum_path_check_core #(
  parameter int MAX_ROWS    = gzsp_pkg::DEFAULT_MAX_ROWS,
  parameter int MAX_COLUMNS = gzsp_pkg::DEFAULT_MAX_COLUMNS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gzsp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [gzsp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cell_is_plus_one,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           zero_path_exists,
  output logic signed [gzsp_pkg::OUT_W-1:0] least_path_sum,
  output logic signed [gzsp_pkg::OUT_W-1:0] greatest_path_sum
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CFG_W = gzsp_pkg::CFG_W;
  localparam int SUM_W = gzsp_pkg::SUM_W;
  localparam int CNT_W = gzsp_pkg::CNT_W;

  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] column_count;
  logic [CFG_W-1:0] rows_eff;
  logic [CFG_W-1:0] cols_eff;
  logic [CFG_W:0]   path_len;
  logic [CFG_W:0]   half_len;

  // entry stage
  logic [RW-1:0]    cur_row;
  logic [CW-1:0]    cur_col;
  logic [CNT_W-1:0] plus_count;
  logic [CNT_W-1:0] minus_count;
  logic [CNT_W-1:0] plus_next;
  logic [CNT_W-1:0] minus_next;
  logic             row_end;
  logic             grid_end;
  logic             in_fire;

  // update stage
  logic                s1_valid;
  logic                s1_last;
  logic                s1_counts_ok;
  logic [CW-1:0]       s1_col;
  gzsp_pkg::step_ctl_t s1_ctl;
  logic                s1_fwd;
  gzsp_pkg::sum_t      fwd_min;
  gzsp_pkg::sum_t      fwd_max;
  logic [2*SUM_W-1:0]  rd_data;
  gzsp_pkg::sum_t      up_min;
  gzsp_pkg::sum_t      up_max;
  gzsp_pkg::sum_t      left_min;
  gzsp_pkg::sum_t      left_max;
  gzsp_pkg::sum_t      new_min;
  gzsp_pkg::sum_t      new_max;

  // output buffer
  logic                                s1_fin;
  logic                                res_zero;
  logic [1:0]                          results_held;
  logic                                spare_valid;
  logic                                spare_zero;
  logic signed [gzsp_pkg::OUT_W-1:0]   spare_least;
  logic signed [gzsp_pkg::OUT_W-1:0]   spare_greatest;

  logic [2*SUM_W-1:0] row_mem [MAX_COLUMNS];

  assign rows_eff = gzsp_pkg::clamp_size(row_count, MAX_ROWS);
  assign cols_eff = gzsp_pkg::clamp_size(column_count, MAX_COLUMNS);
  assign path_len = (CFG_W+1)'(rows_eff) + (CFG_W+1)'(cols_eff) - (CFG_W+1)'(1);
  assign half_len = path_len >> 1;

  assign row_end  = (32'(cur_col) + 32'd1) >= 32'(cols_eff);
  assign grid_end = row_end && ((32'(cur_row) + 32'd1) >= 32'(rows_eff));

  assign plus_next  = plus_count + CNT_W'(cell_is_plus_one);
  assign minus_next = minus_count + CNT_W'(!cell_is_plus_one);

  assign s1_fin       = s1_valid && s1_last;
  assign results_held = 2'(s1_fin) + 2'(out_valid) + 2'(spare_valid);

  // a final cell enters only when its result is sure to find room in the buffer
  assign in_ready = !grid_end || ((results_held - 2'(out_valid && out_ready)) < 2'd2);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CFG_W'(1);
      column_count <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        gzsp_pkg::REG_ROW_COUNT:    row_count    <= cfg_data;
        gzsp_pkg::REG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      cur_row     <= '0;
      cur_col     <= '0;
      plus_count  <= '0;
      minus_count <= '0;
    end else if (in_fire) begin
      if (grid_end) begin
        cur_row     <= '0;
        cur_col     <= '0;
        plus_count  <= '0;
        minus_count <= '0;
      end else begin
        plus_count  <= plus_next;
        minus_count <= minus_next;
        if (row_end) begin
          cur_col <= '0;
          cur_row <= cur_row + RW'(1);
        end else begin
          cur_col <= cur_col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col           <= cur_col;
      s1_last          <= grid_end;
      s1_ctl.first_row <= (cur_row == '0);
      s1_ctl.first_col <= (cur_col == '0);
      s1_ctl.plus      <= cell_is_plus_one;
      s1_counts_ok     <= !path_len[0] && (plus_next >= CNT_W'(half_len)) &&
                          (minus_next >= CNT_W'(half_len));
      // the entry is written back this same edge: take the new value instead
      s1_fwd  <= s1_valid && (s1_col == cur_col);
      fwd_min <= new_min;
      fwd_max <= new_max;
    end
  end

  // row buffer: read on entry, write back from the update stage
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      row_mem[s1_col] <= {new_max, new_min};
    end
    if (in_fire) begin
      rd_data <= row_mem[cur_col];
    end
  end

  assign up_min = s1_fwd ? fwd_min : gzsp_pkg::sum_t'(rd_data[SUM_W-1:0]);
  assign up_max = s1_fwd ? fwd_max : gzsp_pkg::sum_t'(rd_data[2*SUM_W-1:SUM_W]);

  gzsp_step u_step (
    .ctl      (s1_ctl),
    .up_min   (up_min),
    .up_max   (up_max),
    .left_min (left_min),
    .left_max (left_max),
    .lo       (new_min),
    .hi       (new_max)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      left_min <= '0;
      left_max <= '0;
    end else if (s1_valid) begin
      left_min <= new_min;
      left_max <= new_max;
    end
  end

  assign res_zero = s1_counts_ok && (new_min <= 0) && (new_max >= 0);

  // the spare entry only fills while the output register holds a result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid   <= spare_valid || s1_fin;
      spare_valid <= spare_valid && s1_fin;
    end else begin
      spare_valid <= spare_valid || s1_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (spare_valid) begin
        zero_path_exists  <= spare_zero;
        least_path_sum    <= spare_least;
        greatest_path_sum <= spare_greatest;
      end else if (s1_fin) begin
        zero_path_exists  <= res_zero;
        least_path_sum    <= new_min[gzsp_pkg::OUT_W-1:0];
        greatest_path_sum <= new_max[gzsp_pkg::OUT_W-1:0];
      end
    end
    if (s1_fin && (spare_valid || (out_valid && !out_ready))) begin
      spare_zero     <= res_zero;
      spare_least    <= new_min[gzsp_pkg::OUT_W-1:0];
      spare_greatest <= new_max[gzsp_pkg::OUT_W-1:0];
    end
  end

endmodule

/* rtl/gzsp_checker.sv */
module gzsp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               zero_path_exists,
  input logic signed [gzsp_pkg::OUT_W-1:0]  least_path_sum,
  input logic signed [gzsp_pkg::OUT_W-1:0]  greatest_path_sum
);

  // the output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(zero_path_exists) &&
    $stable(least_path_sum) && $stable(greatest_path_sum))
    else $error("stalled result changed");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> least_path_sum <= greatest_path_sum)
    else $error("least sum above greatest sum");

  a_zero_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_path_exists |-> least_path_sum <= 0 && greatest_path_sum >= 0)
    else $error("zero path reported outside sum range");

  // a result that newly appears needs an input transfer that passed through the update stage
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a final cell");

endmodule

bind grid_zero_sum_path_check_core gzsp_checker u_gzsp_checker (.*);

/* tb/tb_grid_zero_sum_path_check_core.sv */
module tb_grid_zero_sum_path_check_core;

  localparam int CFG_W       = gzsp_pkg::CFG_W;
  localparam int OUT_W       = gzsp_pkg::OUT_W;
  localparam int REG_IDX_W   = gzsp_pkg::REG_IDX_W;
  localparam int MAX_ROWS    = gzsp_pkg::DEFAULT_MAX_ROWS;
  localparam int MAX_COLUMNS = gzsp_pkg::DEFAULT_MAX_COLUMNS;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_CELLS = 450;
  localparam int IDLE_PCT     = 22;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic                    zero_path;
    logic signed [OUT_W-1:0] least;
    logic signed [OUT_W-1:0] greatest;
  } grid_result_t;

  class path_sum_tracker;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    int               up_min [MAX_COLUMNS];
    int               up_max [MAX_COLUMNS];
    int               left_min;
    int               left_max;
    int unsigned      row_pos;
    int unsigned      col_pos;
    int unsigned      plus_cnt;
    int unsigned      minus_cnt;
    grid_result_t     pending_grid_results[$];
    int unsigned      mismatch_count;

    function new();
      rows_reg = 1;
      cols_reg = 1;
      mismatch_count = 0;
      restart_grid();
    endfunction

    function void restart_grid();
      left_min = 0;
      left_max = 0;
      row_pos = 0;
      col_pos = 0;
      plus_cnt = 0;
      minus_cnt = 0;
    endfunction

    function int unsigned effective_size(logic [CFG_W-1:0] raw, int unsigned limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return raw;
    endfunction

    function int unsigned cells_per_grid();
      return effective_size(rows_reg, MAX_ROWS) *
             effective_size(cols_reg, MAX_COLUMNS);
    endfunction

    // Any write restarts the grid in progress.
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == gzsp_pkg::REG_ROW_COUNT) begin
        rows_reg = val;
      end else if (idx == gzsp_pkg::REG_COLUMN_COUNT) begin
        cols_reg = val;
      end
      restart_grid();
    endfunction

    function void note_cell(logic plus);
      int unsigned  rows;
      int unsigned  cols;
      int unsigned  path_len;
      int           v;
      int           lo;
      int           hi;
      bit           row_end;
      bit           grid_end;
      grid_result_t res;
      rows = effective_size(rows_reg, MAX_ROWS);
      cols = effective_size(cols_reg, MAX_COLUMNS);
      v = plus ? 1 : -1;
      if (plus) plus_cnt++;
      else minus_cnt++;

      if (row_pos == 0 && col_pos == 0) begin
        lo = v;
        hi = v;
      end else if (row_pos == 0) begin
        lo = left_min + v;
        hi = left_max + v;
      end else if (col_pos == 0) begin
        lo = up_min[col_pos] + v;
        hi = up_max[col_pos] + v;
      end else begin
        lo = (up_min[col_pos] < left_min ? up_min[col_pos] : left_min) + v;
        hi = (up_max[col_pos] > left_max ? up_max[col_pos] : left_max) + v;
      end
      up_min[col_pos] = lo;
      up_max[col_pos] = hi;
      left_min = lo;
      left_max = hi;

      row_end = (col_pos + 1 >= cols);
      grid_end = row_end && (row_pos + 1 >= rows);
      if (grid_end) begin
        path_len = rows + cols - 1;
        res.zero_path = (path_len % 2 == 0) && plus_cnt >= path_len / 2 &&
                        minus_cnt >= path_len / 2 && lo <= 0 && hi >= 0;
        res.least = OUT_W'(lo);
        res.greatest = OUT_W'(hi);
        pending_grid_results.push_back(res);
        restart_grid();
      end else if (row_end) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
    endfunction

    function void flag(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic z, logic signed [OUT_W-1:0] lo,
                               logic signed [OUT_W-1:0] hi);
      grid_result_t want;
      if (pending_grid_results.size() == 0) begin
        flag($sformatf("unexpected result: zero=%0b least=%0d greatest=%0d", z, lo, hi));
        return;
      end
      want = pending_grid_results.pop_front();
      if (z !== want.zero_path || lo !== want.least || hi !== want.greatest) begin
        flag($sformatf({"result mismatch: expected zero=%0b least=%0d greatest=%0d, ",
                        "got zero=%0b least=%0d greatest=%0d"},
                       want.zero_path, want.least, want.greatest, z, lo, hi));
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]     cfg_index = gzsp_pkg::REG_ROW_COUNT;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     cell_is_plus_one = 1'b0;
  logic                     out_ready = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic                     zero_path_exists;
  logic signed [OUT_W-1:0]  least_path_sum;
  logic signed [OUT_W-1:0]  greatest_path_sum;

  bit              no_idle = 1'b0;
  int unsigned     cells_sent = 0;
  int unsigned     cycle_count = 0;
  path_sum_tracker paths = new();

  grid_zero_sum_path_check_core uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cell_is_plus_one  (cell_is_plus_one),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .zero_path_exists  (zero_path_exists),
    .least_path_sum    (least_path_sum),
    .greatest_path_sum (greatest_path_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      paths.check_result(zero_path_exists, least_path_sum, greatest_path_sum);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_cell(input logic plus);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_is_plus_one <= plus;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    paths.note_cell(plus);
    cells_sent++;
  endtask

  // Cells go out LSB first.
  task automatic send_bits(input int n, input logic [31:0] bits);
    for (int i = 0; i < n; i++) send_cell(bits[i]);
  endtask

  task automatic send_grid(input int unsigned n_cells, input int unsigned plus_pct);
    repeat (n_cells) send_cell($urandom_range(99) < plus_pct);
  endtask

  // Hold the sender until every result is out, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (paths.pending_grid_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] rows_raw,
                           input logic [CFG_W-1:0] cols_raw);
    cfg_we <= 1'b1;
    cfg_index <= gzsp_pkg::REG_ROW_COUNT;
    cfg_data <= rows_raw;
    @(posedge clk);
    paths.write_reg(gzsp_pkg::REG_ROW_COUNT, rows_raw);
    cfg_index <= gzsp_pkg::REG_COLUMN_COUNT;
    cfg_data <= cols_raw;
    @(posedge clk);
    paths.write_reg(gzsp_pkg::REG_COLUMN_COUNT, cols_raw);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(11))
      0: return '0;
      1: return CFG_W'(1);
      default: return CFG_W'($urandom_range(2, 7));
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n_grids;
    int unsigned n_cells;
    int unsigned plus_pct;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single cell grids: odd path length, never a zero path
    configure(1, 1);
    send_bits(2, 32'b01);
    // zero row count acts as one; balanced, all plus, all minus
    settle();
    configure(0, 2);
    send_bits(6, 32'b00_11_01);
    // interior cells, then a grid cut short by the next write
    settle();
    configure(2, 3);
    send_bits(6, 32'b010101);
    send_bits(3, 32'b111);
    // single column: every cell reuses the same row buffer entry
    settle();
    configure(3, 0);
    send_bits(3, 32'b001);

    // oversized column count clamps to the maximum: one wide grid
    settle();
    configure(1, 11'd1025);
    send_grid(paths.cells_per_grid(), 100);

    cells_sent = 0;
    phase = 0;
    while (cells_sent < RANDOM_CELLS) begin
      phase++;
      no_idle = (phase >= 2 && phase < 4);
      settle();
      configure(pick_size(), pick_size());
      n_cells = paths.cells_per_grid();
      n_grids = $urandom_range(1, 8);
      for (int g = 0; g < n_grids; g++) begin
        case ($urandom_range(7))
          0: plus_pct = 25;
          1: plus_pct = 75;
          default: plus_pct = 50;
        endcase
        if ($urandom_range(9) == 0) settle();
        if (n_cells > 1 && $urandom_range(11) == 0) begin
          // abandon this grid; the next write restarts it
          send_grid($urandom_range(1, n_cells - 1), plus_pct);
          break;
        end
        send_grid(n_cells, plus_pct);
      end
    end
    no_idle = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    if (paths.mismatch_count == 0 && paths.pending_grid_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
